/* rtl/tlik_pkg.sv */
// Package for the two-link leg IK and PD servo: fixed-point widths, pipeline
// cell record types, request/result payloads and the CORDIC arctangent table.
// No dependencies.
package tlik_pkg;

  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_STEPS    = 16;
  localparam int GOAL_SHIFT      = 30 - ANGLE_FRAC_BITS;
  localparam int RATE_SHIFT      = ANGLE_FRAC_BITS - 10;

  localparam int SQ_RAD_W  = 64;
  localparam int SQ_REM_W  = 33;
  localparam int SQ_ROOT_W = 32;
  localparam int SQRT_CELLS = SQ_ROOT_W;

  localparam int DV_DVD_W = 31;
  localparam int DV_REM_W = 32;
  localparam int DIV_CELLS = DV_DVD_W;

  localparam int CW = 34;
  localparam int STEP_W = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CW-1:0] Q30_HALF_PI = 34'd1686629713;
  localparam logic [CW-1:0] Q30_ONE_57  = 34'd1685774664;
  localparam logic [30:0]   Q30_ONE     = 31'h4000_0000;

  localparam int LANE_PHI  = 0;
  localparam int LANE_PSI  = 1;
  localparam int LANE_KNEE = 2;
  localparam int LANES     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIP_P_GAIN,
    REG_KNEE_P_GAIN,
    REG_HIP_D_GAIN,
    REG_KNEE_D_GAIN,
    REG_TORQUE_LIMIT,
    REG_LINK_LENGTH
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_z;
    logic signed [15:0] hip_angle;
    logic signed [15:0] knee_angle;
    logic signed [15:0] hip_rate;
    logic signed [15:0] knee_rate;
  } req_t;

  typedef struct packed {
    logic signed [15:0] hip_torque;
    logic signed [15:0] knee_torque;
    logic signed [15:0] hip_goal_angle;
    logic signed [15:0] knee_goal_angle;
    logic               unreachable;
    logic [1:0]         clamped_mask;
  } rsp_t;

  typedef struct packed {
    logic [SQ_RAD_W-1:0]  rad;
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [DV_DVD_W-1:0] dvd;
    logic [DV_REM_W-1:0] rem;
    logic [DV_DVD_W-1:0] q;
    logic [DV_REM_W-1:0] dvs;
    logic                ovf;
  } div_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  function automatic logic [31:0] atan_q30(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/tlik_req_if.sv */
// Request channel: valid/ready handshake carrying one foot target and joint sample.
// Depends on tlik_pkg.
interface tlik_req_if;
  logic          valid;
  logic          ready;
  tlik_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/tlik_rsp_if.sv */
// Result channel: valid/ready handshake carrying torques, goals and flags.
// Depends on tlik_pkg.
interface tlik_rsp_if;
  logic          valid;
  logic          ready;
  tlik_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/two_link_leg_ik_pd_servo.sv */
// Two-link leg inverse kinematics with PD joint servo, top level.
// Depends on tlik_pkg, tlik_req_if, tlik_rsp_if and the sqrt, div and cordic cells.
//
//   channel  direction  handshake            payload
//   req_i    in         valid/ready          foot target, joint angles and rates
//   rsp_o    out        valid/ready          torques, goal angles, flags
//   cfg      in         cfg_we_i, no wait    cfg_idx_i selects, cfg_data_i value
//
// One request per cycle while no result waits in the output register; each result
// passes through the root chain (32 cells), the divider chain (31 cells), the second root chain
// (32 cells) and the CORDIC chain (16 cells) plus the multiply and round stages.
// Reset clears the stage valid bits and config registers; link_length resets to 3768.
// While a result waits in the output register the whole chain holds.
module two_link_leg_ik_pd_servo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tlik_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tlik_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tlik_req_if.sink                        req_i,
  tlik_rsp_if.source                      rsp_o
);
  import tlik_pkg::*;

  localparam int ST_SUM  = 2;
  localparam int ST_SQ1  = ST_SUM + 1;
  localparam int ST_DIV  = ST_SQ1 + SQRT_CELLS;
  localparam int ST_ARG  = ST_DIV + DIV_CELLS;
  localparam int ST_MUL  = ST_ARG + 1;
  localparam int ST_RAD  = ST_MUL + 1;
  localparam int ST_SQ2  = ST_RAD + 1;
  localparam int ST_COR  = ST_SQ2 + SQRT_CELLS;
  localparam int ST_GOAL = ST_COR + CORDIC_STEPS;
  localparam int ST_PD   = ST_GOAL + 1;
  localparam int ST_OUT  = ST_PD + 1;

  localparam int GW   = CW + 2;
  localparam int PD_W = 34 + RATE_SHIFT + 2;
  localparam logic [SQ_RAD_W-1:0] RAD_ONE = 64'h1000_0000_0000_0000;

  typedef struct packed {
    logic signed [15:0]       ha;
    logic signed [15:0]       ka;
    logic signed [15:0]       hr;
    logic signed [15:0]       kr;
    logic [15:0]              ax;
    logic                     xneg;
    logic                     xzero;
    logic                     sumzero;
    logic                     unreach;
    logic                     kneg;
    logic [31:0]              mag;
    logic [LANES-1:0][30:0]   qm;
    logic [LANES-1:0]         qneg;
    logic signed [15:0]       hg;
    logic signed [15:0]       kg;
  } aux_t;

  logic [15:0] hip_p_gain_q, knee_p_gain_q, hip_d_gain_q, knee_d_gain_q;
  logic [14:0] torque_limit_q;
  logic [13:0] link_length_q;
  logic [27:0] l2;
  logic [28:0] two_l2_q;
  logic        lzero;

  logic              adv;
  logic [ST_OUT:0]   vld_q;
  req_t              in_q;
  logic signed [31:0] xx_q, zz_q;
  logic [31:0]       sum_q;
  aux_t              aux_q [1:ST_PD];
  aux_t              aux_d [1:ST_PD];

  sqrt_t   s1_feed;
  sqrt_t   s1 [0:SQRT_CELLS];
  div_t    dv_feed [0:LANES-1];
  div_t    dv [0:LANES-1][0:DIV_CELLS];
  logic [30:0] qsat [0:LANES-1];
  logic        qneg [0:LANES-1];
  logic [61:0] m_q [0:LANES-1];
  logic [SQ_RAD_W-1:0] rad_q [0:LANES-1];
  sqrt_t   s2_feed [0:LANES-1];
  sqrt_t   s2 [0:LANES-1][0:SQRT_CELLS];
  cordic_t cr_feed [0:LANES-1];
  cordic_t cr [0:LANES-1][0:CORDIC_STEPS];

  logic signed [GW-1:0] hip_v, knee_v;
  logic signed [15:0]   hg_q, kg_q;
  logic signed [16:0]   he, ke, hnr, knr;
  logic signed [33:0]   hp_q, hd_q, kp_q, kd_q;
  logic [16:0]          ht, kt;
  rsp_t                 rsp_q;

  function automatic logic signed [15:0] goal_round(input logic signed [GW-1:0] v);
    logic signed [GW-1:0] r;
    r = (v + GW'(1 << (GOAL_SHIFT - 1))) >>> GOAL_SHIFT;
    if (r > GW'(32767)) begin
      return 16'sh7FFF;
    end else if (r < -GW'(32768)) begin
      return -16'sh8000;
    end
    return r[15:0];
  endfunction

  function automatic logic [16:0] pd_out(input logic signed [33:0] p,
                                         input logic signed [33:0] d,
                                         input logic [14:0] lim_u);
    logic signed [PD_W-1:0] s;
    logic signed [PD_W-1:0] r;
    logic signed [PD_W-1:0] lim;
    s   = PD_W'(p) + (PD_W'(d) <<< RATE_SHIFT);
    r   = (s + PD_W'(1 << (ANGLE_FRAC_BITS - 1))) >>> ANGLE_FRAC_BITS;
    lim = $signed({{(PD_W-15){1'b0}}, lim_u});
    if (r > lim) begin
      return {1'b1, lim[15:0]};
    end else if (r < -lim) begin
      return {1'b1, 16'(-lim)};
    end
    return {1'b0, r[15:0]};
  endfunction

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hip_p_gain_q   <= '0;
      knee_p_gain_q  <= '0;
      hip_d_gain_q   <= '0;
      knee_d_gain_q  <= '0;
      torque_limit_q <= '0;
      link_length_q  <= 14'd3768;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_HIP_P_GAIN:   hip_p_gain_q   <= cfg_data_i;
        REG_KNEE_P_GAIN:  knee_p_gain_q  <= cfg_data_i;
        REG_HIP_D_GAIN:   hip_d_gain_q   <= cfg_data_i;
        REG_KNEE_D_GAIN:  knee_d_gain_q  <= cfg_data_i;
        REG_TORQUE_LIMIT: torque_limit_q <= cfg_data_i[14:0];
        REG_LINK_LENGTH:  link_length_q  <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  assign l2    = 28'(link_length_q) * 28'(link_length_q);
  assign lzero = (link_length_q == '0);

  always_ff @(posedge clk_i) begin
    two_l2_q <= {l2, 1'b0};
  end

  // handshake: advance unless a result waits
  assign adv         = !vld_q[ST_OUT] || rsp_o.ready;
  assign req_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[ST_OUT-1:0], req_i.valid};
    end
  end

  // side data along the chain
  always_comb begin
    aux_d[1]       = '0;
    aux_d[1].ha    = in_q.hip_angle;
    aux_d[1].ka    = in_q.knee_angle;
    aux_d[1].hr    = in_q.hip_rate;
    aux_d[1].kr    = in_q.knee_rate;
    aux_d[1].ax    = in_q.target_x[15] ? 16'(-in_q.target_x) : in_q.target_x;
    aux_d[1].xneg  = in_q.target_x[15];
    aux_d[1].xzero = (in_q.target_x == '0);
    for (int s = 2; s <= ST_PD; s++) begin
      aux_d[s] = aux_q[s-1];
    end
    aux_d[ST_SQ1].sumzero = (sum_q == '0);
    aux_d[ST_SQ1].unreach = (sum_q == '0) || (sum_q > {2'b00, two_l2_q, 1'b0});
    aux_d[ST_SQ1].kneg    = (sum_q < {3'b000, two_l2_q});
    aux_d[ST_SQ1].mag     = (sum_q < {3'b000, two_l2_q}) ?
                            ({3'b000, two_l2_q} - sum_q) : (sum_q - {3'b000, two_l2_q});
    for (int k = 0; k < LANES; k++) begin
      aux_d[ST_ARG].qm[k]   = qsat[k];
      aux_d[ST_ARG].qneg[k] = qneg[k];
    end
    aux_d[ST_PD].hg = hg_q;
    aux_d[ST_PD].kg = kg_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q  <= req_i.data;
      xx_q  <= $signed(in_q.target_x) * $signed(in_q.target_x);
      zz_q  <= $signed(in_q.target_z) * $signed(in_q.target_z);
      sum_q <= $unsigned(xx_q) + $unsigned(zz_q);
      for (int s = 1; s <= ST_PD; s++) begin
        aux_q[s] <= aux_d[s];
      end
    end
  end

  // distance root
  always_comb begin
    s1_feed.rad  = {sum_q, 32'h0};
    s1_feed.rem  = '0;
    s1_feed.root = '0;
  end

  assign s1[0] = s1_feed;

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sq1
    tlik_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .d_i   (s1[k]),
      .d_o   (s1[k+1])
    );
  end

  // acos argument quotients
  always_comb begin
    dv_feed[LANE_PHI].rem = {1'b0, aux_q[ST_DIV-1].ax, 15'h0};
    dv_feed[LANE_PHI].dvd = '0;
    dv_feed[LANE_PHI].dvs = s1[SQRT_CELLS].root;
    dv_feed[LANE_PHI].q   = '0;
    dv_feed[LANE_PHI].ovf = dv_feed[LANE_PHI].rem >= dv_feed[LANE_PHI].dvs;

    dv_feed[LANE_PSI].rem = {1'b0, s1[SQRT_CELLS].root[31:1]};
    dv_feed[LANE_PSI].dvd = {s1[SQRT_CELLS].root[0], 30'h0};
    dv_feed[LANE_PSI].dvs = {1'b0, link_length_q, 17'h0};
    dv_feed[LANE_PSI].q   = '0;
    dv_feed[LANE_PSI].ovf = dv_feed[LANE_PSI].rem >= dv_feed[LANE_PSI].dvs;

    dv_feed[LANE_KNEE].rem = {1'b0, aux_q[ST_DIV-1].mag[31:1]};
    dv_feed[LANE_KNEE].dvd = {aux_q[ST_DIV-1].mag[0], 30'h0};
    dv_feed[LANE_KNEE].dvs = {3'b000, two_l2_q};
    dv_feed[LANE_KNEE].q   = '0;
    dv_feed[LANE_KNEE].ovf = dv_feed[LANE_KNEE].rem >= dv_feed[LANE_KNEE].dvs;
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign dv[l][0] = dv_feed[l];

    for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
      tlik_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (adv),
        .d_i   (dv[l][k]),
        .d_o   (dv[l][k+1])
      );
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        m_q[l]   <= 62'(aux_q[ST_ARG].qm[l]) * 62'(aux_q[ST_ARG].qm[l]);
        rad_q[l] <= RAD_ONE - {2'b00, m_q[l]};
      end
    end

    always_comb begin
      s2_feed[l].rad  = rad_q[l];
      s2_feed[l].rem  = '0;
      s2_feed[l].root = '0;
    end

    assign s2[l][0] = s2_feed[l];

    for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sq2
      tlik_sqrt_cell u_cell (
        .clk_i (clk_i),
        .en_i  (adv),
        .d_i   (s2[l][k]),
        .d_o   (s2[l][k+1])
      );
    end

    always_comb begin
      if (aux_q[ST_COR-1].qneg[l]) begin
        cr_feed[l].x = $signed({2'b00, s2[l][SQRT_CELLS].root});
        cr_feed[l].y = $signed({3'b000, aux_q[ST_COR-1].qm[l]});
        cr_feed[l].z = $signed(Q30_HALF_PI);
      end else begin
        cr_feed[l].x = $signed({3'b000, aux_q[ST_COR-1].qm[l]});
        cr_feed[l].y = $signed({2'b00, s2[l][SQRT_CELLS].root});
        cr_feed[l].z = '0;
      end
    end

    assign cr[l][0] = cr_feed[l];

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cor
      tlik_cordic_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (adv),
        .step_i (STEP_W'(k)),
        .d_i    (cr[l][k]),
        .d_o    (cr[l][k+1])
      );
    end
  end

  // saturate quotients to one, zero the phi quotient for a zero sum, pick the knee sign
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qsat[l] = (dv[l][DIV_CELLS].ovf || (dv[l][DIV_CELLS].q > Q30_ONE)) ?
                Q30_ONE : dv[l][DIV_CELLS].q;
      qneg[l] = 1'b0;
    end
    if (aux_q[ST_ARG-1].sumzero) begin
      qsat[LANE_PHI] = '0;
    end
    qneg[LANE_KNEE] = aux_q[ST_ARG-1].kneg && !lzero && (qsat[LANE_KNEE] != '0);
  end

  // goals
  always_comb begin
    if (aux_q[ST_GOAL-1].xneg) begin
      hip_v = GW'($signed(Q30_ONE_57)) - GW'(cr[LANE_PHI][CORDIC_STEPS].z)
              + GW'(cr[LANE_PSI][CORDIC_STEPS].z);
    end else if (aux_q[ST_GOAL-1].xzero) begin
      hip_v = GW'(cr[LANE_PSI][CORDIC_STEPS].z);
    end else begin
      hip_v = GW'(cr[LANE_PHI][CORDIC_STEPS].z) + GW'(cr[LANE_PSI][CORDIC_STEPS].z)
              - GW'($signed(Q30_ONE_57));
    end
    knee_v = -GW'(cr[LANE_KNEE][CORDIC_STEPS].z);
  end

  // PD terms
  always_comb begin
    he  = 17'(hg_q) - 17'(aux_q[ST_PD-1].ha);
    ke  = 17'(kg_q) - 17'(aux_q[ST_PD-1].ka);
    hnr = -17'(aux_q[ST_PD-1].hr);
    knr = -17'(aux_q[ST_PD-1].kr);
    ht  = pd_out(hp_q, hd_q, torque_limit_q);
    kt  = pd_out(kp_q, kd_q, torque_limit_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hg_q <= goal_round(hip_v);
      kg_q <= goal_round(knee_v);
      hp_q <= $signed({1'b0, hip_p_gain_q}) * he;
      hd_q <= $signed({1'b0, hip_d_gain_q}) * hnr;
      kp_q <= $signed({1'b0, knee_p_gain_q}) * ke;
      kd_q <= $signed({1'b0, knee_d_gain_q}) * knr;
      rsp_q.hip_torque      <= ht[15:0];
      rsp_q.knee_torque     <= kt[15:0];
      rsp_q.hip_goal_angle  <= aux_q[ST_PD].hg;
      rsp_q.knee_goal_angle <= aux_q[ST_PD].kg;
      rsp_q.unreachable     <= aux_q[ST_PD].unreach;
      rsp_q.clamped_mask    <= {kt[16], ht[16]};
    end
  end

  assign rsp_o.valid = vld_q[ST_OUT];
  assign rsp_o.data  = rsp_q;
endmodule

/* rtl/tlik_sqrt_cell.sv */
// Square root cell: resolves one root bit per cycle while enabled, restoring form.
// Depends on tlik_pkg.
module tlik_sqrt_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  tlik_pkg::sqrt_t d_i,
  output tlik_pkg::sqrt_t d_o
);
  import tlik_pkg::*;

  logic [SQ_REM_W+1:0] cur;
  logic [SQ_REM_W+1:0] trial;
  logic                ge;
  sqrt_t               d_d;
  sqrt_t               d_q;

  always_comb begin
    cur      = {d_i.rem, d_i.rad[SQ_RAD_W-1 -: 2]};
    trial    = {{(SQ_REM_W-SQ_ROOT_W){1'b0}}, d_i.root, 2'b01};
    ge       = cur >= trial;
    d_d.rad  = {d_i.rad[SQ_RAD_W-3:0], 2'b00};
    d_d.rem  = ge ? SQ_REM_W'(cur - trial) : cur[SQ_REM_W-1:0];
    d_d.root = {d_i.root[SQ_ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;
endmodule

/* rtl/tlik_div_cell.sv */
// Divider cell: resolves one quotient bit per cycle while enabled, restoring form.
// Depends on tlik_pkg.
module tlik_div_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  tlik_pkg::div_t d_i,
  output tlik_pkg::div_t d_o
);
  import tlik_pkg::*;

  logic [DV_REM_W:0] cur;
  logic [DV_REM_W:0] dvs_x;
  logic              ge;
  div_t              d_d;
  div_t              d_q;

  always_comb begin
    cur     = {d_i.rem, d_i.dvd[DV_DVD_W-1]};
    dvs_x   = {1'b0, d_i.dvs};
    ge      = cur >= dvs_x;
    d_d.dvd = {d_i.dvd[DV_DVD_W-2:0], 1'b0};
    d_d.rem = ge ? DV_REM_W'(cur - dvs_x) : cur[DV_REM_W-1:0];
    d_d.q   = {d_i.q[DV_DVD_W-2:0], ge};
    d_d.dvs = d_i.dvs;
    d_d.ovf = d_i.ovf;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;
endmodule

/* rtl/tlik_cordic_cell.sv */
// Vectoring CORDIC cell: one micro-rotation per cycle while enabled, angle accumulated in Q30.
// Depends on tlik_pkg (record type and arctangent table).
module tlik_cordic_cell (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [tlik_pkg::STEP_W-1:0] step_i,
  input  tlik_pkg::cordic_t           d_i,
  output tlik_pkg::cordic_t           d_o
);
  import tlik_pkg::*;

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] at;
  logic                 ypos;
  cordic_t              d_d;
  cordic_t              d_q;

  always_comb begin
    xs   = $signed(d_i.x) >>> step_i;
    ys   = $signed(d_i.y) >>> step_i;
    at   = $signed({{(CW-32){1'b0}}, atan_q30(step_i)});
    ypos = !d_i.y[CW-1] && (d_i.y != '0);
    if (ypos) begin
      d_d.x = d_i.x + ys;
      d_d.y = d_i.y - xs;
      d_d.z = d_i.z + at;
    end else begin
      d_d.x = d_i.x - ys;
      d_d.y = d_i.y + xs;
      d_d.z = d_i.z - at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;
endmodule
